>>> src/bitmap_find_next_set_top_macros.svh
// assertion macros for the bitmap find-next-set block
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef BITMAP_FIND_NEXT_SET_TOP_MACROS_SVH
`define BITMAP_FIND_NEXT_SET_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BFNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BFNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BFNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/bfns_pkg.sv
// shared constants, types and the trailing-zero function of the bitmap block
// no dependencies
package bfns_pkg;

  localparam int ACT_W        = 2;
  localparam int IDX_W        = 12;
  localparam int LEN_W        = 13;
  localparam int WORD_W       = 32;
  localparam int BSEL_W       = 5;
  localparam int DEF_MAX_BITS = 4096;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BSEL_W-1:0] bsel_t;

  localparam len_t LEN_RESET = len_t'(4096);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FIND  = 2'd2
  } action_t;

  // control of the word check during a search
  typedef struct packed {
    logic  is_first;
    logic  is_last;
    bsel_t lo_bit;
    bsel_t hi_bit;
  } scan_ctl_t;

  typedef struct packed {
    logic  hit;
    bsel_t offset;
  } scan_res_t;

  // trailing zeros of a nonzero word by binary narrowing
  function automatic bsel_t tz32(input word_t x);
    word_t      v;
    logic [5:0] cnt;
    v   = x;
    cnt = 6'd1;
    if (v[15:0] == 16'd0) begin
      cnt = cnt + 6'd16;
      v   = v >> 16;
    end
    if (v[7:0] == 8'd0) begin
      cnt = cnt + 6'd8;
      v   = v >> 8;
    end
    if (v[3:0] == 4'd0) begin
      cnt = cnt + 6'd4;
      v   = v >> 4;
    end
    if (v[1:0] == 2'd0) begin
      cnt = cnt + 6'd2;
      v   = v >> 2;
    end
    return bsel_t'(cnt - {5'd0, v[0]});
  endfunction

endpackage

>>> src/bfns_ifs.sv
// valid/ready channel interfaces for the bitmap block's request and response words
// depends on bfns_pkg
interface bfns_in_if;
  import bfns_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  idx_t             bit_index;
  logic             bit_value;

  modport source (output valid, action, bit_index, bit_value, input ready);
  modport sink   (input valid, action, bit_index, bit_value, output ready);
endinterface

interface bfns_out_if;
  import bfns_pkg::*;
  logic valid;
  logic ready;
  logic bit_read;
  len_t found_index;

  modport source (output valid, bit_read, found_index, input ready);
  modport sink   (input valid, bit_read, found_index, output ready);
endinterface

>>> src/bitmap_find_next_set_top.sv
// top level of the bitmap find-next-set block: word memory, sequencer, result register
// depends on bfns_pkg, bfns_ifs, bfns_scan and bitmap_find_next_set_top_macros.svh
//
//   channel   dir  handshake          word
//   in_chan   in   valid/ready        action, bit_index, bit_value
//   out_chan  out  valid/ready        bit_read, found_index
//   cfg_*     in   cfg_wr_en          cfg_wr_data -> length_bits
//
// a write or read passes through the access state to the result register; a find scans
//   word by word, one memory read per word, until a hit or the last word of the length
// a find starting at or past the length, or an unused action, goes straight to the result
//   state; the next word is accepted once the sequencer returns to idle from the result state
// after reset a clearing pass zeroes the memory, one word per cycle; no word is accepted
//   until it ends, cfg writes still land
// the result register frees the sequencer: the next word is taken while a result waits,
//   and only the hand-over into the result register waits on out_chan.ready
`include "bitmap_find_next_set_top_macros.svh"

module bitmap_find_next_set_top #(
  parameter int MAX_BITS = bfns_pkg::DEF_MAX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bfns_in_if.sink               in_chan,
  bfns_out_if.source            out_chan,
  input  logic                  cfg_wr_en,
  input  logic [bfns_pkg::LEN_W-1:0] cfg_wr_data
);
  import bfns_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef logic [AW-1:0] waddr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // bitmap storage, one synchronous read port and one write port
  word_t  mem [NUM_WORDS];
  word_t  rd_data_r;
  waddr_t rd_addr;
  logic   mem_we;
  waddr_t mem_wa;
  word_t  mem_wd;

  state_t           state_r,     state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_bit_r,   out_bit_nxt;
  len_t             out_found_r, out_found_nxt;
  len_t             len_cfg_r,   len_cfg_nxt;
  waddr_t           clr_addr_r,  clr_addr_nxt;
  logic [ACT_W-1:0] act_r,       act_nxt;
  idx_t             idx_r,       idx_nxt;
  logic             val_r,       val_nxt;
  logic             in_range_r,  in_range_nxt;
  len_t             len_r,       len_nxt;
  waddr_t           first_r,     first_nxt;
  waddr_t           last_r,      last_nxt;
  waddr_t           scan_addr_r, scan_addr_nxt;
  waddr_t           chk_addr_r,  chk_addr_nxt;
  logic             res_bit_r,   res_bit_nxt;
  len_t             res_found_r, res_found_nxt;

  logic      in_accept;
  waddr_t    in_word;
  logic      in_range;
  len_t      len_eff;
  len_t      len_m1;
  waddr_t    len_last;
  word_t     bit_mask;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign in_accept            = in_chan.valid && (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.bit_read    = out_bit_r;
  assign out_chan.found_index = out_found_r;

  // request decode: word address, range check, length saturated to the bitmap size
  always_comb begin
    in_word  = waddr_t'(in_chan.bit_index[IDX_W-1:BSEL_W]);
    in_range = (32'(in_chan.bit_index) < MAX_BITS);
    len_eff  = (32'(len_cfg_r) > MAX_BITS) ? len_t'(MAX_BITS) : len_cfg_r;
    len_m1   = len_eff - len_t'(1);
    len_last = waddr_t'(len_m1[LEN_W-1:BSEL_W]);
    bit_mask = word_t'(1) << idx_r[BSEL_W-1:0];
  end

  assign scan_ctl.is_first = (chk_addr_r == first_r);
  assign scan_ctl.is_last  = (chk_addr_r == last_r);
  assign scan_ctl.lo_bit   = idx_r[BSEL_W-1:0];
  assign scan_ctl.hi_bit   = len_r[BSEL_W-1:0];

  bfns_scan u_scan (
    .word (rd_data_r),
    .ctl  (scan_ctl),
    .res  (scan_res)
  );

  // sequencer; the read-modify-write finishes before the next word is taken,
  // so a read never meets a pending write to the same word
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    out_found_nxt = out_found_r;
    len_cfg_nxt   = cfg_wr_en ? cfg_wr_data : len_cfg_r;
    clr_addr_nxt  = clr_addr_r;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    in_range_nxt  = in_range_r;
    len_nxt       = len_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    scan_addr_nxt = scan_addr_r;
    chk_addr_nxt  = chk_addr_r;
    res_bit_nxt   = res_bit_r;
    res_found_nxt = res_found_r;
    rd_addr       = scan_addr_r;
    mem_we        = 1'b0;
    mem_wa        = clr_addr_r;
    mem_wd        = word_t'(0);

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = waddr_t'(clr_addr_r + 1'b1);
        if (clr_addr_r == waddr_t'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = in_word;
        if (in_accept) begin
          act_nxt       = in_chan.action;
          idx_nxt       = in_chan.bit_index;
          val_nxt       = in_chan.bit_value;
          in_range_nxt  = in_range;
          len_nxt       = len_eff;
          first_nxt     = in_word;
          last_nxt      = len_last;
          res_bit_nxt   = 1'b0;
          res_found_nxt = len_t'(0);
          case (in_chan.action)
            ACT_WRITE, ACT_READ: begin
              state_nxt = ST_ACCESS;
            end
            ACT_FIND: begin
              if ({1'b0, in_chan.bit_index} >= len_eff) begin
                // start at or past the length: nothing to search
                res_found_nxt = len_eff;
                state_nxt     = ST_RESULT;
              end else begin
                scan_addr_nxt = waddr_t'(in_word + 1'b1);
                chk_addr_nxt  = in_word;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        mem_wa = first_r;
        if (act_r == ACT_READ) begin
          res_bit_nxt = in_range_r & rd_data_r[idx_r[BSEL_W-1:0]];
        end else begin
          mem_we = in_range_r;
          mem_wd = val_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
        end
        state_nxt = ST_RESULT;
      end
      ST_SCAN: begin
        // read the next word while checking the one just read
        scan_addr_nxt = waddr_t'(scan_addr_r + 1'b1);
        chk_addr_nxt  = scan_addr_r;
        if (scan_res.hit) begin
          res_found_nxt = len_t'({chk_addr_r, scan_res.offset});
          state_nxt     = ST_RESULT;
        end else if (scan_ctl.is_last) begin
          res_found_nxt = len_r;
          state_nxt     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = res_bit_r;
          out_found_nxt = res_found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      len_cfg_r   <= LEN_RESET;
      clr_addr_r  <= waddr_t'(0);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      len_cfg_r   <= len_cfg_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_bit_r   <= out_bit_nxt;
      out_found_r <= out_found_nxt;
      act_r       <= act_nxt;
      idx_r       <= idx_nxt;
      val_r       <= val_nxt;
      in_range_r  <= in_range_nxt;
      len_r       <= len_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      scan_addr_r <= scan_addr_nxt;
      chk_addr_r  <= chk_addr_nxt;
      res_bit_r   <= res_bit_nxt;
      res_found_r <= res_found_nxt;
    end
  end

  `BFNS_ASSERT_NOW(a_clear_no_out, clk, rst_n, state_r == ST_CLEAR, !out_valid_r, "result during clear")
  `BFNS_ASSERT_NOW(a_scan_in_window, clk, rst_n, state_r == ST_SCAN, chk_addr_r <= last_r, "scan past last word")
  `BFNS_ASSERT_NOW(a_scan_no_write, clk, rst_n, state_r == ST_SCAN, !mem_we, "memory write during scan")
  `BFNS_ASSERT_NEXT(a_out_from_result, clk, rst_n, (state_r != ST_RESULT) && !out_valid_r, !out_valid_r, "result outside result state")
  `BFNS_ASSERT_NOW(a_found_bound, clk, rst_n, (state_r == ST_RESULT) && (act_r == ACT_FIND), res_found_r <= len_r, "found index past length")

endmodule

>>> src/bfns_scan.sv
// word check of the search: masks the word to the search window and finds the lowest set bit
// depends on bfns_pkg
module bfns_scan (
  input  bfns_pkg::word_t     word,
  input  bfns_pkg::scan_ctl_t ctl,
  output bfns_pkg::scan_res_t res
);
  import bfns_pkg::*;

  word_t lo_mask;
  word_t hi_mask;
  word_t masked;

  always_comb begin
    lo_mask = ctl.is_first ? (~word_t'(0) << ctl.lo_bit) : ~word_t'(0);
    // a length that ends on a word boundary keeps the whole last word
    if (ctl.is_last && (ctl.hi_bit != bsel_t'(0))) begin
      hi_mask = (word_t'(1) << ctl.hi_bit) - word_t'(1);
    end else begin
      hi_mask = ~word_t'(0);
    end
    masked     = word & lo_mask & hi_mask;
    res.hit    = (masked != word_t'(0));
    res.offset = tz32(masked);
  end

endmodule
